>>> rtl/cdc_pkg.sv
// Package: shared constants, codes, types and the sigmoid table of the conv block.
`timescale 1ns / 1ps

package cdc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = SAMPLE_BITS - 4;
    localparam int STEP_BITS    = FRAC_BITS - 2;
    localparam int CHANNELS_DEF = 1024;
    localparam int TAPS_DEF     = 4;
    localparam int SIG_W        = 17;

    localparam logic [1:0] MODE_LOAD_WEIGHT  = 2'd0;
    localparam logic [1:0] MODE_LOAD_HISTORY = 2'd1;
    localparam logic [1:0] MODE_FILTER       = 2'd2;

    localparam logic [0:0] REG_SILU_ENABLE = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_MAC,
        ST_ROUND,
        ST_SIG,
        ST_SILU,
        ST_DONE
    } cdc_state_t;

    typedef struct packed {
        logic step1;
        logic step2;
    } silu_ctrl_t;

    // Sigmoid at k/4, Q1.16.
    function automatic logic [SIG_W-1:0] sig_tab(input logic [5:0] k);
        logic [SIG_W-1:0] v;
        case (k)
            6'd0:  v = 17'd32768;
            6'd1:  v = 17'd36843;
            6'd2:  v = 17'd40793;
            6'd3:  v = 17'd44511;
            6'd4:  v = 17'd47911;
            6'd5:  v = 17'd50941;
            6'd6:  v = 17'd53581;
            6'd7:  v = 17'd55834;
            6'd8:  v = 17'd57724;
            6'd9:  v = 17'd59287;
            6'd10: v = 17'd60565;
            6'd11: v = 17'd61598;
            6'd12: v = 17'd62428;
            6'd13: v = 17'd63090;
            6'd14: v = 17'd63615;
            6'd15: v = 17'd64030;
            6'd16: v = 17'd64357;
            6'd17: v = 17'd64614;
            6'd18: v = 17'd64816;
            6'd19: v = 17'd64974;
            6'd20: v = 17'd65097;
            6'd21: v = 17'd65194;
            6'd22: v = 17'd65269;
            6'd23: v = 17'd65328;
            6'd24: v = 17'd65374;
            6'd25: v = 17'd65410;
            6'd26: v = 17'd65438;
            6'd27: v = 17'd65459;
            6'd28: v = 17'd65476;
            6'd29: v = 17'd65489;
            6'd30: v = 17'd65500;
            6'd31: v = 17'd65508;
            6'd32: v = 17'd65514;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/cdc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps

module cdc_ram #(
    parameter int DEPTH = cdc_pkg::CHANNELS_DEF,
    parameter int WIDTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cdc_silu.sv
// SiLU unit: two registered steps, sigmoid interpolation then the final product.
`timescale 1ns / 1ps

module cdc_silu #(
    parameter int YW = 24
) (
    input  logic                    clk,
    input  cdc_pkg::silu_ctrl_t     ctrl,
    input  logic signed [YW-1:0]    y,
    output logic signed [YW-1:0]    result
);

    localparam int SB       = cdc_pkg::SAMPLE_BITS;
    localparam int STEP     = cdc_pkg::STEP_BITS;
    localparam int SW       = cdc_pkg::SIG_W;
    localparam int MAG_W    = SB - 1;
    localparam int IDX_W    = MAG_W - STEP;
    localparam int DIFF_W   = 13;
    localparam int INTERP_W = DIFF_W + STEP;
    localparam int PW       = SB + SW + 1;

    localparam logic signed [YW-1:0] LIM  = YW'(2 ** (SB - 1));
    localparam logic signed [YW-1:0] NLIM = -LIM;

    logic signed [YW-1:0]  mag;
    logic [MAG_W-1:0]      a;
    logic [IDX_W-1:0]      idx;
    logic [STEP-1:0]       fr;
    logic [SW-1:0]         t_lo;
    logic [SW-1:0]         t_hi;
    logic [DIFF_W-1:0]     diff;

    logic                  big_pos_reg;
    logic                  big_neg_reg;
    logic                  neg_reg;
    logic [SB-1:0]         y_lo_reg;
    logic [SW-1:0]         base_reg;
    logic [INTERP_W-1:0]   interp_reg;

    logic [SW-1:0]         s_pos;
    logic [SW-1:0]         sig;
    logic signed [PW-1:0]  prod_next;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  rounded;
    logic signed [PW-17:0] scaled;

    always_comb
    begin
        mag  = y[YW-1] ? -y : y;
        a    = mag[MAG_W-1:0];
        idx  = a[MAG_W-1:STEP];
        fr   = a[STEP-1:0];
        t_lo = cdc_pkg::sig_tab(6'(idx));
        t_hi = cdc_pkg::sig_tab(6'(idx) + 6'd1);
        diff = DIFF_W'(t_hi - t_lo);
    end

    // Step one: table lookup and interpolation product.
    always_ff @(posedge clk)
    begin
        if (ctrl.step1)
        begin
            big_pos_reg <= (y >= LIM);
            big_neg_reg <= (y <= NLIM);
            neg_reg     <= y[YW-1];
            y_lo_reg    <= y[SB-1:0];
            base_reg    <= t_lo;
            interp_reg  <= INTERP_W'(diff) * INTERP_W'(fr);
        end
    end

    always_comb
    begin
        s_pos     = base_reg + SW'(interp_reg >> STEP);
        sig       = neg_reg ? (SW'(2 ** 16) - s_pos) : s_pos;
        prod_next = $signed(y_lo_reg) * $signed({1'b0, sig});
    end

    // Step two: y times sigmoid.
    always_ff @(posedge clk)
    begin
        if (ctrl.step2)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        rounded = prod_reg + PW'(2 ** 15);
        scaled  = rounded[PW-1:16];
        if (big_pos_reg)
        begin
            result = y;
        end
        else if (big_neg_reg)
        begin
            result = '0;
        end
        else
        begin
            result = YW'(scaled);
        end
    end

endmodule

>>> rtl/causal_depthwise_conv1d_silu.sv
// Top level: causal depthwise multi-tap FIR per channel with optional SiLU.
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// input     in_valid / in_ready           mode, channel, tap, sample_value
// output    out_valid / out_ready         filtered_value, out_channel, saturated
// config    psel, penable, pwrite, pready paddr, pwdata, prdata (silu_enable at 0)
//
// One item at a time through the taps' shared multiplier and a read-modify-write
// of the history and weight memories (registered read port).
// A load item ends with its write-back; a filter item then makes TAPS passes
// through the multiplier, a rounding step and, with SiLU, two SiLU steps.
// After reset the history memory is zeroed, one entry per channel; no item
// is taken during it. A stalled result sits in the output register while the
// next item is taken; a later result waits in its last step until that one leaves.

module causal_depthwise_conv1d_silu #(
    parameter int CHANNELS = cdc_pkg::CHANNELS_DEF,
    parameter int TAPS     = cdc_pkg::TAPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [9:0]  channel,
    input  logic [1:0]  tap,
    input  logic signed [15:0] sample_value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] filtered_value,
    output logic [9:0]  out_channel,
    output logic        saturated,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB    = cdc_pkg::SAMPLE_BITS;
    localparam int FRAC  = cdc_pkg::FRAC_BITS;
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HW    = (TAPS - 1) * SB;
    localparam int WW    = TAPS * SB;
    localparam int TW    = $clog2(TAPS);
    localparam int CW    = $clog2(TAPS + 1);
    localparam int ACC_W = 2 * SB + $clog2(TAPS) + 1;
    localparam int YW    = ACC_W - FRAC;

    localparam logic signed [YW-1:0] YMAX = YW'(2 ** (SB - 1) - 1);
    localparam logic signed [YW-1:0] YMIN = -YMAX - YW'(1);

    // Control state
    cdc_pkg::cdc_state_t state_reg;
    cdc_pkg::cdc_state_t state_next;
    logic [AW-1:0]       clr_cnt_reg;
    logic [CW-1:0]       count_reg;
    logic                out_valid_reg;
    logic                silu_enable_reg;

    // Item held while it is worked on
    logic [1:0]           mode_reg;
    logic [9:0]           ch_reg;
    logic [1:0]           tap_reg;
    logic signed [SB-1:0] x_reg;

    // Datapath
    logic signed [2*SB-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [YW-1:0]   y_reg;

    logic signed [SB-1:0]   filtered_value_reg;
    logic [9:0]             out_channel_reg;
    logic                   saturated_reg;

    // Memories and control strobes
    logic            item_ok;
    logic            rd_en;
    logic            hist_we;
    logic            wt_we;
    logic            out_load;
    cdc_pkg::silu_ctrl_t silu_ctrl;
    logic [AW-1:0]   hist_waddr;
    logic [HW-1:0]   hist_wdata;
    logic [WW-1:0]   wt_wdata;
    logic [HW-1:0]   hist_rd;
    logic [WW-1:0]   wt_rd;
    logic [HW-1:0]   hist_loaded;
    logic [HW+SB-1:0] hist_shift;
    logic [WW-1:0]   samp_vec;

    logic signed [SB-1:0]   samp [TAPS];
    logic signed [SB-1:0]   wts  [TAPS];
    logic [TW-1:0]          mac_idx;
    logic signed [2*SB-1:0] prod_next;

    logic signed [YW-1:0]   silu_result;
    logic signed [YW-1:0]   val;
    logic signed [SB-1:0]   fv_next;
    logic                   sat_next;

    logic cfg_write;

    // ------------------------------------------------------------------
    // Configuration port: one register, silu_enable, written in the access
    // phase at paddr 0 to 3. Reads there return it; 4 to 7 read as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silu_enable_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2:2] == cdc_pkg::REG_SILU_ENABLE))
        begin
            silu_enable_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == cdc_pkg::REG_SILU_ENABLE)
        begin
            prdata = {31'd0, silu_enable_reg};
        end
    end

    // ------------------------------------------------------------------
    // Memories: history (TAPS-1 samples per channel, slot 0 in the low
    // bits) and weights (TAPS per channel). Both are read on accept; the
    // modify step writes back the history or the weights, as the mode needs.
    // ------------------------------------------------------------------
    cdc_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (HW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (rd_en),
        .raddr (AW'(channel)),
        .rdata (hist_rd)
    );

    cdc_ram #(
        .DEPTH (CHANNELS),
        .WIDTH (WW)
    ) u_wt_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (AW'(ch_reg)),
        .wdata (wt_wdata),
        .re    (rd_en),
        .raddr (AW'(channel)),
        .rdata (wt_rd)
    );

    // Drop items for channels beyond the memory and for the unused mode.
    assign item_ok = (32'(channel) < CHANNELS)
                   && ((mode == cdc_pkg::MODE_LOAD_WEIGHT)
                       || (mode == cdc_pkg::MODE_LOAD_HISTORY)
                       || (mode == cdc_pkg::MODE_FILTER));

    // ------------------------------------------------------------------
    // Write-back data
    // ------------------------------------------------------------------
    always_comb
    begin
        // Load one weight lane or one history slot.
        wt_wdata    = wt_rd;
        hist_loaded = hist_rd;
        for (int i = 0; i < TAPS; i++)
        begin
            if (32'(tap_reg) == i)
            begin
                wt_wdata[i*SB +: SB] = x_reg;
            end
        end
        for (int i = 0; i < TAPS - 1; i++)
        begin
            if (32'(tap_reg) == i)
            begin
                hist_loaded[i*SB +: SB] = x_reg;
            end
        end

        // Filter: drop the oldest slot, new sample into the top slot.
        hist_shift = {x_reg, hist_rd} >> SB;

        if (state_reg == cdc_pkg::ST_CLEAR)
        begin
            hist_waddr = clr_cnt_reg;
            hist_wdata = '0;
        end
        else
        begin
            hist_waddr = AW'(ch_reg);
            hist_wdata = (mode_reg == cdc_pkg::MODE_FILTER) ? hist_shift[HW-1:0]
                                                            : hist_loaded;
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate over the taps, one product per cycle
    // ------------------------------------------------------------------
    assign samp_vec = {x_reg, hist_rd};

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            samp[i] = samp_vec[i*SB +: SB];
            wts[i]  = wt_rd[i*SB +: SB];
        end
        mac_idx   = count_reg[TW-1:0];
        prod_next = samp[mac_idx] * wts[mac_idx];
    end

    // ------------------------------------------------------------------
    // SiLU and saturation
    // ------------------------------------------------------------------
    cdc_silu #(
        .YW (YW)
    ) u_silu (
        .clk    (clk),
        .ctrl   (silu_ctrl),
        .y      (y_reg),
        .result (silu_result)
    );

    always_comb
    begin
        val      = silu_enable_reg ? silu_result : y_reg;
        sat_next = 1'b0;
        fv_next  = val[SB-1:0];
        if (val > YMAX)
        begin
            fv_next  = YMAX[SB-1:0];
            sat_next = 1'b1;
        end
        else if (val < YMIN)
        begin
            fv_next  = YMIN[SB-1:0];
            sat_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(CHANNELS - 1))
                begin
                    state_next = cdc_pkg::ST_IDLE;
                end
            end
            cdc_pkg::ST_IDLE:
            begin
                if (in_valid && item_ok)
                begin
                    state_next = cdc_pkg::ST_MODIFY;
                end
            end
            cdc_pkg::ST_MODIFY:
            begin
                state_next = (mode_reg == cdc_pkg::MODE_FILTER) ? cdc_pkg::ST_MAC
                                                                : cdc_pkg::ST_IDLE;
            end
            cdc_pkg::ST_MAC:
            begin
                if (count_reg == CW'(TAPS))
                begin
                    state_next = cdc_pkg::ST_ROUND;
                end
            end
            cdc_pkg::ST_ROUND:
            begin
                state_next = silu_enable_reg ? cdc_pkg::ST_SIG : cdc_pkg::ST_DONE;
            end
            cdc_pkg::ST_SIG:
            begin
                state_next = cdc_pkg::ST_SILU;
            end
            cdc_pkg::ST_SILU:
            begin
                state_next = cdc_pkg::ST_DONE;
            end
            cdc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = cdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready        = 1'b0;
        rd_en           = 1'b0;
        hist_we         = 1'b0;
        wt_we           = 1'b0;
        out_load        = 1'b0;
        silu_ctrl.step1 = 1'b0;
        silu_ctrl.step2 = 1'b0;
        case (state_reg)
            cdc_pkg::ST_CLEAR:
            begin
                hist_we = 1'b1;
            end
            cdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid && item_ok;
            end
            cdc_pkg::ST_MODIFY:
            begin
                wt_we   = (mode_reg == cdc_pkg::MODE_LOAD_WEIGHT)
                       && (32'(tap_reg) < TAPS);
                hist_we = ((mode_reg == cdc_pkg::MODE_LOAD_HISTORY)
                           && (32'(tap_reg) < TAPS - 1))
                       || (mode_reg == cdc_pkg::MODE_FILTER);
            end
            cdc_pkg::ST_SIG:
            begin
                silu_ctrl.step1 = 1'b1;
            end
            cdc_pkg::ST_SILU:
            begin
                silu_ctrl.step2 = 1'b1;
            end
            cdc_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdc_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cdc_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (state_reg == cdc_pkg::ST_MODIFY)
            begin
                count_reg <= '0;
            end
            else if (state_reg == cdc_pkg::ST_MAC)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Hold the item for the write-back and the filter pass.
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            ch_reg   <= channel;
            tap_reg  <= tap;
            x_reg    <= sample_value;
        end

        // Seed the sum with the rounding half.
        if (state_reg == cdc_pkg::ST_MODIFY)
        begin
            acc_reg <= ACC_W'(2 ** (FRAC - 1));
        end
        else if (state_reg == cdc_pkg::ST_MAC)
        begin
            if (count_reg < CW'(TAPS))
            begin
                prod_reg <= prod_next;
            end
            if (count_reg != '0)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end

        // Floor shift to the sample format.
        if (state_reg == cdc_pkg::ST_ROUND)
        begin
            y_reg <= acc_reg[ACC_W-1:FRAC];
        end

        if (out_load)
        begin
            filtered_value_reg <= fv_next;
            out_channel_reg    <= ch_reg;
            saturated_reg      <= sat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = filtered_value_reg;
    assign out_channel    = out_channel_reg;
    assign saturated      = saturated_reg;

endmodule
